// File: hw/rtl/chunked_tile_map_lookup_macros.svh
// chunked_tile_map_lookup_macros.svh: assertion macros for the chunk lookup block
// no dependencies; included by the modules that carry assertions

`ifndef CHUNKED_TILE_MAP_LOOKUP_MACROS_SVH
`define CHUNKED_TILE_MAP_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CTML_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTML_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ctml_pkg.sv
// ctml_pkg: field widths, register indexes and shared types of the chunk lookup block
// no dependencies; used by ctml_coord, ctml_search and chunked_tile_map_lookup

package ctml_pkg;

    // input field widths
    localparam int STAGE_W   = 12;
    localparam int WORLD_W   = 16;
    localparam int VP_W      = 15;

    // result field widths
    localparam int CHUNK_F_W = 13;
    localparam int KEY_W     = 2 * CHUNK_F_W;
    localparam int OFF_F_W   = 3;
    localparam int TILE_F_W  = 6;
    localparam int SLOT_F_W  = 6;

    // in-chunk offset before truncation, chunk sides never exceed 64
    localparam int OFF_W     = 6;

    // configuration register indexes
    localparam logic CFG_VIEWPORT_X = 1'b0;
    localparam logic CFG_VIEWPORT_Y = 1'b1;

    // outcome of one table search
    typedef struct packed {
        logic                done;
        logic [SLOT_F_W-1:0] slot;
        logic                created;
        logic                full;
    } t_srch_res;

endpackage

// File: hw/rtl/ctml_coord.sv
// ctml_coord: six-stage coordinate pipeline, pixel to tile, floor split into chunk and offset
// depends on ctml_pkg; divisions by the tile and chunk sizes use reciprocal multiplies

module ctml_coord #(
    parameter int CHUNK_W     = 8,
    parameter int CHUNK_H     = 8,
    parameter int TILE_PIXELS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_command,
    input  logic        [ctml_pkg::STAGE_W-1:0] i_stage_x,
    input  logic        [ctml_pkg::STAGE_W-1:0] i_stage_y,
    input  logic signed [ctml_pkg::WORLD_W-1:0] i_world_x,
    input  logic signed [ctml_pkg::WORLD_W-1:0] i_world_y,
    input  logic signed [ctml_pkg::VP_W-1:0]    i_viewport_x,
    input  logic signed [ctml_pkg::VP_W-1:0]    i_viewport_y,
    output logic                                o_key_valid,
    output logic        [ctml_pkg::KEY_W-1:0]   o_key,
    output logic                                o_done,
    output logic        [ctml_pkg::CHUNK_F_W-1:0] o_chunk_x,
    output logic        [ctml_pkg::CHUNK_F_W-1:0] o_chunk_y,
    output logic        [ctml_pkg::OFF_W-1:0]   o_offset_x,
    output logic        [ctml_pkg::OFF_W-1:0]   o_offset_y,
    output logic        [ctml_pkg::TILE_F_W-1:0] o_tile_index
);

    // pixel to tile: floor(v / TILE_PIXELS) = (v * TP_MUL) >> RCP_SHIFT for 12-bit v
    localparam int RCP_SHIFT = 24;
    localparam int TP_MUL    = (1 << RCP_SHIFT) / TILE_PIXELS + 1;
    localparam int TP_MUL_W  = RCP_SHIFT + 1;
    localparam int TXP_W     = ctml_pkg::STAGE_W + TP_MUL_W;

    // world coordinate range and bias that makes it non-negative before the split
    localparam int WX_W      = ctml_pkg::WORLD_W + 1;
    localparam int U_W       = WX_W;
    localparam int NEG_SPAN  = 1 << (ctml_pkg::WORLD_W - 1);
    localparam int BIAS_XK   = (NEG_SPAN + CHUNK_W - 1) / CHUNK_W;
    localparam int BIAS_YK   = (NEG_SPAN + CHUNK_H - 1) / CHUNK_H;
    localparam int BIAS_X    = BIAS_XK * CHUNK_W;
    localparam int BIAS_Y    = BIAS_YK * CHUNK_H;

    // chunk split: floor(u / CHUNK_*) = (u * C*_MUL) >> RCP_SHIFT for 17-bit u
    localparam int CX_MUL    = (1 << RCP_SHIFT) / CHUNK_W + 1;
    localparam int CY_MUL    = (1 << RCP_SHIFT) / CHUNK_H + 1;
    localparam int CMUL_W    = RCP_SHIFT;
    localparam int QP_W      = U_W + CMUL_W;
    localparam int Q_W       = U_W - 1;
    localparam int TI_W      = 2 * ctml_pkg::OFF_W;
    localparam int NSTG      = 6;

    logic [NSTG-1:0]                 r_vld;
    logic                            r_cmd;
    logic signed [ctml_pkg::WORLD_W-1:0] r_wx_in, r_wy_in;
    logic [TXP_W-1:0]                r_tx_prod, r_ty_prod;
    logic [U_W-1:0]                  r_ux, r_uy;
    logic [QP_W-1:0]                 r_qx_prod, r_qy_prod;
    logic [Q_W-1:0]                  r_qx, r_qy;
    logic [ctml_pkg::CHUNK_F_W-1:0]  r_cx, r_cy;
    logic [ctml_pkg::OFF_W-1:0]      r_ox, r_oy;
    logic [ctml_pkg::TILE_F_W-1:0]   r_tile;

    logic [ctml_pkg::STAGE_W-1:0]    tile_x, tile_y;
    logic signed [WX_W-1:0]          wx_sel, wy_sel;
    logic [U_W-1:0]                  rem_x, rem_y;
    logic [TI_W-1:0]                 tile_full;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_start};
        end
    end

    // world coordinate selection and viewport offset
    always_comb begin
        tile_x = r_tx_prod[RCP_SHIFT +: ctml_pkg::STAGE_W];
        tile_y = r_ty_prod[RCP_SHIFT +: ctml_pkg::STAGE_W];
        wx_sel = r_cmd ? WX_W'(r_wx_in)
                       : (WX_W'($signed({1'b0, tile_x})) + WX_W'(i_viewport_x));
        wy_sel = r_cmd ? WX_W'(r_wy_in)
                       : (WX_W'($signed({1'b0, tile_y})) + WX_W'(i_viewport_y));
    end

    // remainder after the floor division, and the in-chunk tile index
    always_comb begin
        rem_x     = r_ux - U_W'(U_W'(r_qx) * U_W'(CHUNK_W));
        rem_y     = r_uy - U_W'(U_W'(r_qy) * U_W'(CHUNK_H));
        tile_full = TI_W'(TI_W'(r_oy) * TI_W'(CHUNK_W)) + TI_W'(r_ox);
    end

    // pipeline stages, each held once its item has passed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd     <= i_command;
            r_wx_in   <= i_world_x;
            r_wy_in   <= i_world_y;
            r_tx_prod <= TXP_W'(i_stage_x) * TXP_W'(TP_MUL);
            r_ty_prod <= TXP_W'(i_stage_y) * TXP_W'(TP_MUL);
        end
        if (r_vld[0]) begin
            r_ux <= U_W'(wx_sel) + U_W'(BIAS_X);
            r_uy <= U_W'(wy_sel) + U_W'(BIAS_Y);
        end
        if (r_vld[1]) begin
            r_qx_prod <= QP_W'(r_ux) * QP_W'(CX_MUL);
            r_qy_prod <= QP_W'(r_uy) * QP_W'(CY_MUL);
        end
        if (r_vld[2]) begin
            r_qx <= r_qx_prod[RCP_SHIFT +: Q_W];
            r_qy <= r_qy_prod[RCP_SHIFT +: Q_W];
        end
        if (r_vld[3]) begin
            r_cx <= ctml_pkg::CHUNK_F_W'(U_W'(r_qx) - U_W'(BIAS_XK));
            r_cy <= ctml_pkg::CHUNK_F_W'(U_W'(r_qy) - U_W'(BIAS_YK));
            r_ox <= rem_x[ctml_pkg::OFF_W-1:0];
            r_oy <= rem_y[ctml_pkg::OFF_W-1:0];
        end
        if (r_vld[4]) begin
            r_tile <= tile_full[ctml_pkg::TILE_F_W-1:0];
        end
    end

    assign o_key_valid  = r_vld[4];
    assign o_key        = {r_cy, r_cx};
    assign o_done       = r_vld[5];
    assign o_chunk_x    = r_cx;
    assign o_chunk_y    = r_cy;
    assign o_offset_x   = r_ox;
    assign o_offset_y   = r_oy;
    assign o_tile_index = r_tile;

endmodule

// File: hw/rtl/ctml_search.sv
// ctml_search: chunk position memory, linear scan in slot order and append on a miss
// depends on ctml_pkg and chunked_tile_map_lookup_macros.svh

`include "chunked_tile_map_lookup_macros.svh"

module ctml_search #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ctml_pkg::KEY_W-1:0]    i_key,
    output ctml_pkg::t_srch_res           o_res
);

    localparam int ADDR_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int EXT_W  = 32;

    typedef enum logic [1:0] {
        SR_IDLE = 2'b01,
        SR_SCAN = 2'b10
    } t_sr_state;

    t_sr_state                   r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_issue, n_issue;
    logic [ADDR_W-1:0]           r_cmp, n_cmp;
    logic                        r_pend, n_pend;
    logic [ctml_pkg::KEY_W-1:0]  r_key;
    ctml_pkg::t_srch_res         r_res, n_res;

    // position memory, one read port with registered data and one write port
    logic [ctml_pkg::KEY_W-1:0]  mem [MAX_CHUNKS];
    logic [ctml_pkg::KEY_W-1:0]  r_rdata;
    logic                        rd_en, wr_en;
    logic [ADDR_W-1:0]           rd_addr, wr_addr;
    logic                        hit;
    logic [EXT_W-1:0]            hit_ext, new_ext;

    // scan sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_issue = r_issue;
        n_cmp   = r_cmp;
        n_pend  = r_pend;
        n_res   = r_res;
        n_res.done = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_addr = r_issue[ADDR_W-1:0];
        wr_addr = r_count[ADDR_W-1:0];
        hit     = r_pend && (r_rdata == r_key);
        hit_ext = EXT_W'(r_cmp);
        new_ext = EXT_W'(r_count);
        unique case (r_state)
            SR_IDLE: begin
                if (i_start) begin
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_state = SR_SCAN;
                end
            end
            SR_SCAN: begin
                if (hit) begin
                    n_res   = '{done: 1'b1, slot: hit_ext[ctml_pkg::SLOT_F_W-1:0],
                                created: 1'b0, full: 1'b0};
                    n_pend  = 1'b0;
                    n_state = SR_IDLE;
                end else if (r_issue < r_count) begin
                    rd_en   = 1'b1;
                    n_pend  = 1'b1;
                    n_cmp   = r_issue[ADDR_W-1:0];
                    n_issue = r_issue + 1'b1;
                end else begin
                    // miss: append at the next free slot, or report a full table
                    n_pend  = 1'b0;
                    n_state = SR_IDLE;
                    if (r_count < CNT_W'(MAX_CHUNKS)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                        n_res   = '{done: 1'b1, slot: new_ext[ctml_pkg::SLOT_F_W-1:0],
                                    created: 1'b1, full: 1'b0};
                    end else begin
                        n_res   = '{done: 1'b1, slot: '0, created: 1'b0, full: 1'b1};
                    end
                end
            end
            default: begin
                n_state = SR_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_res   <= n_res;
        end
    end

    // scan index and key
    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_cmp   <= n_cmp;
        if (i_start && (r_state == SR_IDLE)) begin
            r_key <= i_key;
        end
    end

    // memory write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_key;
        end
    end

    // memory read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_res = r_res;

    // checks
    `CTML_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_CHUNKS), "chunk count above table depth")
    `CTML_ASSERT_IMP(a_append_count, i_clk, i_rst_n, r_res.done && r_res.created, r_count == CNT_W'($past(r_count) + 1'b1), "append without count step")
    `CTML_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_res.done, !r_res.done, "search done held longer than one cycle")
    `CTML_ASSERT_IMP(a_full_slot, i_clk, i_rst_n, r_res.done && r_res.full, (r_res.slot == '0) && !r_res.created && (r_count == CNT_W'(MAX_CHUNKS)), "full result inconsistent")

endmodule

// File: hw/rtl/chunked_tile_map_lookup.sv
// chunked_tile_map_lookup: top level, stream ports, viewport registers, sequencing, result register
// depends on ctml_pkg, ctml_coord, ctml_search and chunked_tile_map_lookup_macros.svh

// Chunk lookup for a tile map. Each input transaction carries a position as stage pixels
// (tuser 0) or world tiles (tuser 1); pixel positions are divided by TILE_PIXELS and moved
// by the viewport origin. The world position is split by floor division into a chunk
// coordinate and an in-chunk offset, and the chunk is looked up in slot order in a memory
// of allocated chunk positions; a miss appends it, a miss with all MAX_CHUNKS slots taken
// sets table_full. Each item passes the coordinate pipeline to the chunk key, a scan of the
// position memory at one entry read per cycle, the register of the search outcome and the
// result register. One item is in work at a time; the next is taken as soon as the previous
// result sits in the output register, even if it is not yet taken.
// The position memory needs no clearing after reset, only slots below the count are read.

`include "chunked_tile_map_lookup_macros.svh"

module chunked_tile_map_lookup #(
    parameter int CHUNK_W     = 8,
    parameter int CHUNK_H     = 8,
    parameter int TILE_PIXELS = 16,
    parameter int MAX_CHUNKS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // stage_x[11:0], stage_y[23:12], world_x[39:24], world_y[55:40]
    input  logic        i_s_axis_tuser,   // command[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // chunk_x[12:0], chunk_y[25:13], offset_x[28:26],
                                          // offset_y[31:29], tile_index[37:32], chunk_slot[43:38]
    output logic [1:0]  o_m_axis_tuser    // created[0], table_full[1]
);

    localparam int OUT_USED = 2 * ctml_pkg::CHUNK_F_W + 2 * ctml_pkg::OFF_F_W
                            + ctml_pkg::TILE_F_W + ctml_pkg::SLOT_F_W;
    localparam int OUT_PAD  = 48 - OUT_USED;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_COORD  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_HOLD   = 4'b1000
    } t_state;

    t_state                                r_state, n_state;
    logic signed [ctml_pkg::VP_W-1:0]      r_viewport_x, r_viewport_y;
    logic                                  r_m_valid, n_m_valid;
    logic [47:0]                           r_m_data;
    logic [1:0]                            r_m_user;

    logic                                  in_acc;
    logic                                  load;
    logic signed [ctml_pkg::WORLD_W-1:0]   world_x, world_y;
    logic                                  key_valid, coord_done;
    logic [ctml_pkg::KEY_W-1:0]            key;
    logic [ctml_pkg::CHUNK_F_W-1:0]        chunk_x, chunk_y;
    logic [ctml_pkg::OFF_W-1:0]            offset_x, offset_y;
    logic [ctml_pkg::TILE_F_W-1:0]         tile_index;
    ctml_pkg::t_srch_res                   srch_res;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign world_x         = $signed(i_s_axis_tdata[39:24]);
    assign world_y         = $signed(i_s_axis_tdata[55:40]);

    // coordinate pipeline
    ctml_coord #(
        .CHUNK_W     (CHUNK_W),
        .CHUNK_H     (CHUNK_H),
        .TILE_PIXELS (TILE_PIXELS)
    ) u_coord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc),
        .i_command    (i_s_axis_tuser),
        .i_stage_x    (i_s_axis_tdata[11:0]),
        .i_stage_y    (i_s_axis_tdata[23:12]),
        .i_world_x    (world_x),
        .i_world_y    (world_y),
        .i_viewport_x (r_viewport_x),
        .i_viewport_y (r_viewport_y),
        .o_key_valid  (key_valid),
        .o_key        (key),
        .o_done       (coord_done),
        .o_chunk_x    (chunk_x),
        .o_chunk_y    (chunk_y),
        .o_offset_x   (offset_x),
        .o_offset_y   (offset_y),
        .o_tile_index (tile_index)
    );

    // chunk table search, started as soon as the key is ready
    ctml_search #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_valid),
        .i_key   (key),
        .o_res   (srch_res)
    );

    // item sequencing
    always_comb begin
        n_state   = r_state;
        load      = 1'b0;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_COORD;
                end
            end
            ST_COORD: begin
                if (coord_done) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (srch_res.done) begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        load    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (load) begin
            n_m_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // viewport registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewport_x <= '0;
            r_viewport_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ctml_pkg::CFG_VIEWPORT_X: r_viewport_x <= $signed(i_cfg_data);
                ctml_pkg::CFG_VIEWPORT_Y: r_viewport_y <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {{OUT_PAD{1'b0}},
                         srch_res.slot,
                         tile_index,
                         offset_y[ctml_pkg::OFF_F_W-1:0],
                         offset_x[ctml_pkg::OFF_F_W-1:0],
                         chunk_y,
                         chunk_x};
            r_m_user <= {srch_res.full, srch_res.created};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // checks
    `CTML_ASSERT_NXT(a_one_in_work, i_clk, i_rst_n, in_acc, !o_s_axis_tready, "second item taken while one is in work")
    `CTML_ASSERT_IMP(a_done_in_search, i_clk, i_rst_n, srch_res.done, r_state == ST_SEARCH, "search finished outside search state")

endmodule

// File: verif/tb.sv
// tb: self-checking testbench for chunked_tile_map_lookup, directed table then random lookups
// depends on ctml_pkg and the chunked_tile_map_lookup rtl; keeps its own chunk table model

module tb;

    localparam int CHUNK_COLS    = 8;
    localparam int CHUNK_ROWS    = 8;
    localparam int TILE_PX       = 16;
    localparam int SLOT_COUNT    = 64;
    // full scan plus pipeline, used as settle time before register writes and at the end
    localparam int LOOKUP_CYCLES = SLOT_COUNT + 12;
    localparam int PHASE_ITEMS   = 230;
    localparam int PHASE_COUNT   = 5;

    typedef enum logic {CMD_STAGE = 1'b0, CMD_WORLD = 1'b1} t_cmd;
    typedef enum logic {ROW_LOOKUP = 1'b0, ROW_SETUP = 1'b1} t_row_kind;

    // one position request
    typedef struct packed {
        t_cmd               cmd;
        logic [11:0]        sx;
        logic [11:0]        sy;
        logic signed [15:0] wx;
        logic signed [15:0] wy;
    } t_pos_item;

    // one lookup answer
    typedef struct packed {
        logic signed [12:0] chunk_x;
        logic signed [12:0] chunk_y;
        logic [2:0]         off_x;
        logic [2:0]         off_y;
        logic [5:0]         tile;
        logic [5:0]         slot;
        logic               created;
        logic               full;
    } t_lookup_res;

    // directed stimulus row: a lookup or a register write
    typedef struct packed {
        t_row_kind          kind;
        t_cmd               cmd;
        logic [11:0]        sx;
        logic [11:0]        sy;
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic               cfg_idx;
        logic [14:0]        cfg_val;
        logic               typed;
        t_lookup_res        want;
    } t_dir_row;

    localparam t_lookup_res NO_RESULT = '0;
    localparam int DIR_ROW_COUNT = 24;

    localparam t_dir_row DIR_ROWS [DIR_ROW_COUNT] = '{
        // origin, first slot allocated; stage fields ignored
        '{ROW_LOOKUP, CMD_WORLD, 12'hfff, 12'hfff, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h0000, 3'd0, 3'd0, 6'd0, 6'd0, 1'b1, 1'b0}},
        // same chunk again is a hit
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h0000, 3'd0, 3'd0, 6'd0, 6'd0, 1'b0, 1'b0}},
        // (-1,-1) floors to chunk (-1,-1), offset (7,7)
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'hffff, 16'hffff, 1'b0, 15'h0, 1'b1,
          '{13'h1fff, 13'h1fff, 3'd7, 3'd7, 6'd63, 6'd1, 1'b1, 1'b0}},
        // most negative column, most positive row
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'h8000, 16'h7fff, 1'b0, 15'h0, 1'b1,
          '{13'h1000, 13'h0fff, 3'd0, 3'd7, 6'd56, 6'd2, 1'b1, 1'b0}},
        // most positive column, most negative row
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'h7fff, 16'h8000, 1'b0, 15'h0, 1'b1,
          '{13'h0fff, 13'h1000, 3'd7, 3'd0, 6'd7, 6'd3, 1'b1, 1'b0}},
        // stage origin hits slot 0, world fields ignored
        '{ROW_LOOKUP, CMD_STAGE, 12'h000, 12'h000, 16'hffff, 16'h3039, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h0000, 3'd0, 3'd0, 6'd0, 6'd0, 1'b0, 1'b0}},
        // stage corner, tile 255 in both axes
        '{ROW_LOOKUP, CMD_STAGE, 12'hfff, 12'hfff, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b1,
          '{13'h001f, 13'h001f, 3'd7, 3'd7, 6'd63, 6'd4, 1'b1, 1'b0}},
        // pixel division truncates: (15,16) is tile (0,1)
        '{ROW_LOOKUP, CMD_STAGE, 12'h00f, 12'h010, 16'h1234, 16'h5678, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h0000, 3'd0, 3'd1, 6'd8, 6'd0, 1'b0, 1'b0}},
        // exact negative multiple keeps offset zero
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'hfff8, 16'h0007, 1'b0, 15'h0, 1'b1,
          '{13'h1fff, 13'h0000, 3'd0, 3'd7, 6'd56, 6'd5, 1'b1, 1'b0}},
        // -9 floors to chunk -2, offset 7
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'h0007, 16'hfff7, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h1ffe, 3'd7, 3'd7, 6'd63, 6'd6, 1'b1, 1'b0}},
        // hit on a negative chunk
        '{ROW_LOOKUP, CMD_WORLD, 12'h000, 12'h000, 16'hffff, 16'hffff, 1'b0, 15'h0, 1'b1,
          '{13'h1fff, 13'h1fff, 3'd7, 3'd7, 6'd63, 6'd1, 1'b0, 1'b0}},
        // viewport at most negative column, most positive row
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_X, 15'h4000, 1'b0, NO_RESULT},
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_Y, 15'h3fff, 1'b0, NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'h000, 12'hfff, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'hfff, 12'h000, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'hfff, 12'hfff, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        // viewport at the opposite extremes
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_X, 15'h3fff, 1'b0, NO_RESULT},
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_Y, 15'h4000, 1'b0, NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'hfff, 12'hfff, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'h000, 12'h000, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        // world positions ignore the viewport
        '{ROW_LOOKUP, CMD_WORLD, 12'hfff, 12'hfff, 16'h0008, 16'h0008, 1'b0, 15'h0, 1'b0,
          NO_RESULT},
        // back to a zero viewport
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_X, 15'h0000, 1'b0, NO_RESULT},
        '{ROW_SETUP, CMD_WORLD, 12'h000, 12'h000, 16'h0000, 16'h0000,
          ctml_pkg::CFG_VIEWPORT_Y, 15'h0000, 1'b0, NO_RESULT},
        '{ROW_LOOKUP, CMD_STAGE, 12'h010, 12'h000, 16'h0000, 16'h0000, 1'b0, 15'h0, 1'b1,
          '{13'h0000, 13'h0000, 3'd1, 3'd0, 6'd1, 6'd0, 1'b0, 1'b0}}
    };

    // viewport per random phase; phases 0 and 4 take random values
    localparam logic [14:0] PHASE_VX [PHASE_COUNT] = '{15'h0, 15'h4000, 15'h3fff, 15'h3fff, 15'h0};
    localparam logic [14:0] PHASE_VY [PHASE_COUNT] = '{15'h0, 15'h4000, 15'h3fff, 15'h4000, 15'h0};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;   // stage_x, stage_y, world_x, world_y
    logic        i_s_axis_tuser;   // command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // chunk_x, chunk_y, offset_x, offset_y, tile_index, chunk_slot
    logic [1:0]  o_m_axis_tuser;   // created, table_full

    // model of the chunk table and viewport
    logic [25:0]        chunk_table [SLOT_COUNT];
    int                 chunk_total;
    logic signed [14:0] vp_x;
    logic signed [14:0] vp_y;

    t_lookup_res expected_lookups [$];
    int          mismatch_total;
    bit          calm_stretch;

    chunked_tile_map_lookup #(
        .CHUNK_W     (CHUNK_COLS),
        .CHUNK_H     (CHUNK_ROWS),
        .TILE_PIXELS (TILE_PX),
        .MAX_CHUNKS  (SLOT_COUNT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // floor split, in-order search and append on miss; updates the model table
    function automatic t_lookup_res lookup_chunk(t_pos_item it);
        t_lookup_res r;
        int          col, row, cx, cy, ox, oy;
        logic [25:0] key;
        bit          hit;
        if (it.cmd == CMD_WORLD) begin
            col = it.wx;
            row = it.wy;
        end else begin
            col = int'(it.sx) / TILE_PX + vp_x;
            row = int'(it.sy) / TILE_PX + vp_y;
        end
        cx = col / CHUNK_COLS;
        ox = col % CHUNK_COLS;
        if (ox < 0) begin
            cx = cx - 1;
            ox = ox + CHUNK_COLS;
        end
        cy = row / CHUNK_ROWS;
        oy = row % CHUNK_ROWS;
        if (oy < 0) begin
            cy = cy - 1;
            oy = oy + CHUNK_ROWS;
        end
        key = {cy[12:0], cx[12:0]};
        r   = '0;
        hit = 1'b0;
        for (int i = 0; i < chunk_total; i++) begin
            if (!hit && chunk_table[i] == key) begin
                hit    = 1'b1;
                r.slot = 6'(i);
            end
        end
        if (!hit) begin
            if (chunk_total < SLOT_COUNT) begin
                r.slot                   = 6'(chunk_total);
                chunk_table[chunk_total] = key;
                chunk_total              = chunk_total + 1;
                r.created                = 1'b1;
            end else begin
                r.full = 1'b1;
            end
        end
        r.chunk_x = cx[12:0];
        r.chunk_y = cy[12:0];
        r.off_x   = 3'(ox);
        r.off_y   = 3'(oy);
        r.tile    = 6'(oy * CHUNK_COLS + ox);
        return r;
    endfunction

    // random position: mostly revisits of stored chunks, else fresh stage or world positions
    function automatic t_pos_item pick_position();
        t_pos_item   it;
        int          roll, tcol, trow, rel_col, rel_row;
        logic [25:0] key;
        it.cmd = CMD_WORLD;
        it.sx  = 12'($urandom);
        it.sy  = 12'($urandom);
        it.wx  = 16'($urandom);
        it.wy  = 16'($urandom);
        roll   = int'($urandom_range(99));
        if (roll < 70 && chunk_total > 0) begin
            key     = chunk_table[$urandom_range(chunk_total - 1)];
            tcol    = $signed(key[12:0]) * CHUNK_COLS + int'($urandom_range(CHUNK_COLS - 1));
            trow    = $signed(key[25:13]) * CHUNK_ROWS + int'($urandom_range(CHUNK_ROWS - 1));
            rel_col = tcol - vp_x;
            rel_row = trow - vp_y;
            // for half of the revisits, reach the chunk through stage pixels when the viewport allows it
            if (roll < 35 && rel_col >= 0 && rel_col < 256 && rel_row >= 0 && rel_row < 256) begin
                it.cmd = CMD_STAGE;
                it.sx  = 12'(rel_col * TILE_PX + int'($urandom_range(TILE_PX - 1)));
                it.sy  = 12'(rel_row * TILE_PX + int'($urandom_range(TILE_PX - 1)));
            end else begin
                it.wx = 16'(tcol);
                it.wy = 16'(trow);
            end
        end else if (roll < 85) begin
            it.cmd = CMD_STAGE;
        end
        return it;
    endfunction

    // present one position and wait for its transaction
    task automatic send_item(t_pos_item it, output t_lookup_res want);
        if (!calm_stretch && $urandom_range(99) < 14) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.wy, it.wx, it.sy, it.sx};
        i_s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        want = lookup_chunk(it);
    endtask

    // hold off the sender until every lookup has answered and the block has settled
    task automatic drain_lookups();
        i_s_axis_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (LOOKUP_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [14:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == ctml_pkg::CFG_VIEWPORT_X) vp_x = val;
        else vp_y = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(string name, int want, int seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            mismatch_total++;
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("chunked_tile_map_lookup test failed");
        $finish;
    end

    // result side: random stalls and field-by-field check of each transaction
    initial begin
        t_lookup_res want, seen;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.chunk_x = o_m_axis_tdata[12:0];
                seen.chunk_y = o_m_axis_tdata[25:13];
                seen.off_x   = o_m_axis_tdata[28:26];
                seen.off_y   = o_m_axis_tdata[31:29];
                seen.tile    = o_m_axis_tdata[37:32];
                seen.slot    = o_m_axis_tdata[43:38];
                seen.created = o_m_axis_tuser[0];
                seen.full    = o_m_axis_tuser[1];
                if (expected_lookups.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h_%h",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
                    mismatch_total++;
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("chunk_x", want.chunk_x, seen.chunk_x);
                    check_field("chunk_y", want.chunk_y, seen.chunk_y);
                    check_field("offset_x", want.off_x, seen.off_x);
                    check_field("offset_y", want.off_y, seen.off_y);
                    check_field("tile_index", want.tile, seen.tile);
                    check_field("chunk_slot", want.slot, seen.slot);
                    check_field("created", want.created, seen.created);
                    check_field("table_full", want.full, seen.full);
                end
            end
            i_m_axis_tready <= calm_stretch || ($urandom_range(99) >= 14);
        end
    end

    // stimulus: directed table, then random phases over several viewports
    initial begin
        t_dir_row    r;
        t_pos_item   it;
        t_lookup_res want;
        logic [14:0] vx, vy;
        mismatch_total  = 0;
        chunk_total     = 0;
        vp_x            = '0;
        vp_y            = '0;
        calm_stretch    = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= ctml_pkg::CFG_VIEWPORT_X;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIR_ROW_COUNT; row++) begin
            r = DIR_ROWS[row];
            if (r.kind == ROW_SETUP) begin
                drain_lookups();
                write_register(r.cfg_idx, r.cfg_val);
            end else begin
                it.cmd = r.cmd;
                it.sx  = r.sx;
                it.sy  = r.sy;
                it.wx  = r.wx;
                it.wy  = r.wy;
                send_item(it, want);
                expected_lookups.push_back(r.typed ? r.want : want);
            end
        end

        // table fills early; later phases mix hits with full-table misses
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_lookups();
            calm_stretch = (phase == 0);
            vx = (phase == 0 || phase == 4) ? 15'($urandom) : PHASE_VX[phase];
            vy = (phase == 0 || phase == 4) ? 15'($urandom) : PHASE_VY[phase];
            write_register(ctml_pkg::CFG_VIEWPORT_X, vx);
            write_register(ctml_pkg::CFG_VIEWPORT_Y, vy);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(199) == 0) drain_lookups();
                it = pick_position();
                send_item(it, want);
                expected_lookups.push_back(want);
            end
        end

        calm_stretch = 1'b0;
        drain_lookups();
        if (mismatch_total == 0) begin
            $display("chunked_tile_map_lookup test passed");
        end else begin
            $display("chunked_tile_map_lookup test failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ctml_pkg.sv
hw/rtl/ctml_coord.sv
hw/rtl/ctml_search.sv
hw/rtl/chunked_tile_map_lookup.sv
verif/tb.sv
